/* design/cmh_pkg.sv */
`timescale 1ns / 1ps
package cmh_pkg;

  localparam int HISTORY_DEPTH = 1024;
  localparam int TAG_BITS      = 32;
  localparam int TIME_W        = 64;
  localparam int POS_W         = $clog2(HISTORY_DEPTH);
  localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

  localparam logic ACT_REMEMBER = 1'b0;
  localparam logic ACT_MATCH    = 1'b1;

  localparam logic [TIME_W-1:0] ONE_SECOND_NS = 64'd1000000000;
  localparam logic [TIME_W-1:0] EVICT_LIMIT   = {TIME_W{1'b1}} - ONE_SECOND_NS;

  typedef struct packed {
    logic [TIME_W-1:0]   t;
    logic                vld;
    logic [TAG_BITS-1:0] tag;
  } cmh_entry_t;

  typedef struct packed {
    logic             shift;
    logic             load;
    logic [POS_W-1:0] wr_pos;
  } cmh_chain_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DROP,
    S_LOAD,
    S_EVICT,
    S_SCAN,
    S_AGE
  } cmh_state_t;

endpackage

/* design/cmh_in_if.sv */
`timescale 1ns / 1ps
interface cmh_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [63:0] event_time_ns;
  logic        capture_present;
  logic        command_valid;
  logic [31:0] command_tag;
  logic        consumed_present;
  logic [63:0] consumed_time_ns;

  modport source (
    output valid, action, event_time_ns, capture_present, command_valid,
           command_tag, consumed_present, consumed_time_ns,
    input  ready
  );

  modport sink (
    input  valid, action, event_time_ns, capture_present, command_valid,
           command_tag, consumed_present, consumed_time_ns,
    output ready
  );
endinterface

/* design/cmh_out_if.sv */
`timescale 1ns / 1ps
interface cmh_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic        match_valid;
  logic        approximate;
  logic [31:0] matched_tag;
  logic [63:0] age_ns;

  modport source (
    output valid, found, match_valid, approximate, matched_tag, age_ns,
    input  ready
  );

  modport sink (
    input  valid, found, match_valid, approximate, matched_tag, age_ns,
    output ready
  );
endinterface

/* design/cmh_cell.sv */
`timescale 1ns / 1ps
module cmh_cell (
  input  logic               clk,
  input  logic               shift,
  input  logic               load_sel,
  input  cmh_pkg::cmh_entry_t nb_data,
  input  cmh_pkg::cmh_entry_t wr_data,
  output cmh_pkg::cmh_entry_t data
);

  cmh_pkg::cmh_entry_t data_r;

  // take the neighbour's entry on a shift, the new entry on a load
  always_ff @(posedge clk) begin
    if (shift) begin
      data_r <= nb_data;
    end else if (load_sel) begin
      data_r <= wr_data;
    end
  end

  assign data = data_r;

endmodule

/* design/cmh_chain.sv */
`timescale 1ns / 1ps
module cmh_chain (
  input  logic                   clk,
  input  cmh_pkg::cmh_chain_ctl_t ctl,
  input  cmh_pkg::cmh_entry_t     wr_data,
  output cmh_pkg::cmh_entry_t     head
);

  cmh_pkg::cmh_entry_t cell_data [cmh_pkg::HISTORY_DEPTH];

  // ring: each cell takes from the next, the last from the first
  for (genvar i = 0; i < cmh_pkg::HISTORY_DEPTH; i++) begin : g_cell
    logic load_sel;
    assign load_sel = ctl.load && (ctl.wr_pos == cmh_pkg::POS_W'(i));

    cmh_cell u_cell (
      .clk      (clk),
      .shift    (ctl.shift),
      .load_sel (load_sel),
      .nb_data  (cell_data[(i + 1) % cmh_pkg::HISTORY_DEPTH]),
      .wr_data  (wr_data),
      .data     (cell_data[i])
    );
  end

  assign head = cell_data[0];

endmodule

/* design/timestamped_command_history_match_unit.sv */
`timescale 1ns / 1ps
// Remember: DROP when the history is full, then LOAD, then EVICT for each expired
// entry at the head. Match with capture present: SCAN for one full ring rotation
// (one head compare per cycle), then AGE; capture absent: AGE only. One item at a time;
// a waiting result does not block the next transfer until that item finishes.
// Reset (synchronous, active low) empties the history and clears control;
// entry contents are not cleared and no clearing pass runs.
module timestamped_command_history_match_unit (
  input  logic             clk,
  input  logic             rst_n,
  cmh_in_if.sink           in_ch,
  cmh_out_if.source        out_ch
);

  cmh_pkg::cmh_state_t state_r, state_nxt;
  logic [cmh_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [cmh_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic out_valid_r, out_valid_nxt;
  logic ex_found_r, ex_found_nxt;
  logic ap_found_r, ap_found_nxt;

  logic [cmh_pkg::TIME_W-1:0] t_r, t_nxt;
  logic [cmh_pkg::TIME_W-1:0] cons_r, cons_nxt;
  logic cons_en_r, cons_en_nxt;
  logic cvld_r, cvld_nxt;
  logic [cmh_pkg::TAG_BITS-1:0] ctag_r, ctag_nxt;
  cmh_pkg::cmh_entry_t ex_ent_r, ex_ent_nxt;
  cmh_pkg::cmh_entry_t ap_ent_r, ap_ent_nxt;

  logic o_found_r, o_found_nxt;
  logic o_vld_r, o_vld_nxt;
  logic o_approx_r, o_approx_nxt;
  logic [31:0] o_tag_r, o_tag_nxt;
  logic [63:0] o_age_r, o_age_nxt;

  cmh_pkg::cmh_chain_ctl_t ctl;
  cmh_pkg::cmh_entry_t     head;
  cmh_pkg::cmh_entry_t     wr_data;
  cmh_pkg::cmh_entry_t     sel;
  logic                    live;
  logic                    any_found;

  assign wr_data = '{t: t_r, vld: cvld_r, tag: ctag_r};

  cmh_chain u_chain (
    .clk     (clk),
    .ctl     (ctl),
    .wr_data (wr_data),
    .head    (head)
  );

  assign in_ch.ready = rst_n && (state_r == cmh_pkg::S_IDLE);

  assign live      = ({1'b0, pos_r} < count_r);
  assign sel       = ex_found_r ? ex_ent_r : ap_ent_r;
  assign any_found = ex_found_r || ap_found_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    ex_found_nxt  = ex_found_r;
    ap_found_nxt  = ap_found_r;
    t_nxt         = t_r;
    cons_nxt      = cons_r;
    cons_en_nxt   = cons_en_r;
    cvld_nxt      = cvld_r;
    ctag_nxt      = ctag_r;
    ex_ent_nxt    = ex_ent_r;
    ap_ent_nxt    = ap_ent_r;
    o_found_nxt   = o_found_r;
    o_vld_nxt     = o_vld_r;
    o_approx_nxt  = o_approx_r;
    o_tag_nxt     = o_tag_r;
    o_age_nxt     = o_age_r;
    ctl           = '{shift: 1'b0, load: 1'b0, wr_pos: count_r[cmh_pkg::POS_W-1:0]};

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      cmh_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          t_nxt        = in_ch.event_time_ns;
          cons_nxt     = in_ch.consumed_time_ns;
          cons_en_nxt  = in_ch.consumed_present && (in_ch.consumed_time_ns != '0);
          cvld_nxt     = in_ch.command_valid;
          ctag_nxt     = cmh_pkg::TAG_BITS'(in_ch.command_tag);
          ex_found_nxt = 1'b0;
          ap_found_nxt = 1'b0;
          pos_nxt      = '0;
          if (in_ch.action == cmh_pkg::ACT_REMEMBER) begin
            state_nxt = (count_r == cmh_pkg::CNT_W'(cmh_pkg::HISTORY_DEPTH)) ?
                        cmh_pkg::S_DROP : cmh_pkg::S_LOAD;
          end else if (in_ch.capture_present) begin
            state_nxt = cmh_pkg::S_SCAN;
          end else begin
            state_nxt = cmh_pkg::S_AGE;
          end
        end
      end
      cmh_pkg::S_DROP: begin
        ctl.shift = 1'b1;
        count_nxt = count_r - 1'b1;
        state_nxt = cmh_pkg::S_LOAD;
      end
      cmh_pkg::S_LOAD: begin
        ctl.load  = 1'b1;
        count_nxt = count_r + 1'b1;
        state_nxt = cmh_pkg::S_EVICT;
      end
      cmh_pkg::S_EVICT: begin
        if (count_r != '0 && head.t <= cmh_pkg::EVICT_LIMIT &&
            t_r > head.t + cmh_pkg::ONE_SECOND_NS) begin
          ctl.shift = 1'b1;
          count_nxt = count_r - 1'b1;
        end else begin
          state_nxt = cmh_pkg::S_IDLE;
        end
      end
      cmh_pkg::S_SCAN: begin
        ctl.shift = 1'b1;
        pos_nxt   = pos_r + 1'b1;
        if (live && cons_en_r && head.t == cons_r) begin
          ex_found_nxt = 1'b1;
          ex_ent_nxt   = head;
        end
        if (live && head.t <= t_r) begin
          ap_found_nxt = 1'b1;
          ap_ent_nxt   = head;
        end
        if (pos_r == cmh_pkg::POS_W'(cmh_pkg::HISTORY_DEPTH - 1)) begin
          state_nxt = cmh_pkg::S_AGE;
        end
      end
      cmh_pkg::S_AGE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          o_found_nxt   = any_found;
          o_vld_nxt     = any_found && sel.vld;
          o_approx_nxt  = !ex_found_r && ap_found_r;
          o_tag_nxt     = any_found ? 32'(sel.tag) : '0;
          o_age_nxt     = (any_found && t_r >= sel.t) ? t_r - sel.t : '0;
          state_nxt     = cmh_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cmh_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cmh_pkg::S_IDLE;
      count_r     <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
      ex_found_r  <= 1'b0;
      ap_found_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      ex_found_r  <= ex_found_nxt;
      ap_found_r  <= ap_found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    cons_r     <= cons_nxt;
    cons_en_r  <= cons_en_nxt;
    cvld_r     <= cvld_nxt;
    ctag_r     <= ctag_nxt;
    ex_ent_r   <= ex_ent_nxt;
    ap_ent_r   <= ap_ent_nxt;
    o_found_r  <= o_found_nxt;
    o_vld_r    <= o_vld_nxt;
    o_approx_r <= o_approx_nxt;
    o_tag_r    <= o_tag_nxt;
    o_age_r    <= o_age_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = o_found_r;
  assign out_ch.match_valid = o_vld_r;
  assign out_ch.approximate = o_approx_r;
  assign out_ch.matched_tag = o_tag_r;
  assign out_ch.age_ns      = o_age_r;

endmodule
